### rtl/frie_pkg.sv
// Shared types and constants for the four-register instruction executor.
package frie_pkg;

    localparam int PROGRAM_SIZE   = 128;
    localparam int REGISTER_COUNT = 4;
    localparam int PC_W           = 8;
    localparam int DATA_W         = 32;

    localparam logic [3:0] OP_MOV   = 4'd0;
    localparam logic [3:0] OP_ADD   = 4'd1;
    localparam logic [3:0] OP_SUB   = 4'd2;
    localparam logic [3:0] OP_MUL   = 4'd3;
    localparam logic [3:0] OP_CMP   = 4'd4;
    localparam logic [3:0] OP_JMP   = 4'd5;
    localparam logic [3:0] OP_JZ    = 4'd6;
    localparam logic [3:0] OP_PRINT = 4'd7;

    typedef struct packed {
        logic [3:0]        opcode;
        logic              a_is_reg;
        logic [1:0]        a_reg;
        logic [3:0]        a_imm;
        logic              b_is_reg;
        logic [1:0]        b_reg;
        logic [DATA_W-1:0] b_imm;
        logic [6:0]        jump_target;
    } instr_t;

    typedef struct packed {
        logic [3:0][DATA_W-1:0] regs;
        logic                   zero;
        logic                   negative;
        logic [PC_W-1:0]        pc;
        logic                   halt;
    } core_state_t;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              halted;
        logic              print_valid;
        logic [1:0]        print_reg;
        logic [DATA_W-1:0] print_value;
        logic              zero_out;
        logic              negative_out;
    } result_t;

endpackage

### rtl/frie_exec.sv
// Single-pass execute logic: one instruction against the current core state.
module frie_exec
    import frie_pkg::*;
(
    input  instr_t      instr,
    input  core_state_t state_cur,
    output core_state_t state_nxt,
    output result_t     result
);

    logic [DATA_W-1:0] a_val;
    logic [DATA_W-1:0] b_val;
    logic [DATA_W-1:0] cmp_a;
    logic [DATA_W-1:0] alu_res;
    logic              a_in_range;
    logic              b_in_range;
    logic              pc_end;

    assign a_in_range = {1'b0, instr.a_reg} < 3'(REGISTER_COUNT);
    assign b_in_range = {1'b0, instr.b_reg} < 3'(REGISTER_COUNT);
    assign a_val = a_in_range ? state_cur.regs[instr.a_reg] : '0;
    assign b_val = instr.b_is_reg ? (b_in_range ? state_cur.regs[instr.b_reg] : '0)
                                  : instr.b_imm;
    assign cmp_a = instr.a_is_reg ? a_val : {{(DATA_W-4){1'b0}}, instr.a_imm};
    assign pc_end = state_cur.pc >= PC_W'(PROGRAM_SIZE);

    always_comb begin
        state_nxt          = state_cur;
        alu_res            = '0;
        result.print_valid = 1'b0;
        result.print_reg   = '0;
        result.print_value = '0;
        if (!state_cur.halt) begin
            if (pc_end) begin
                state_nxt.halt = 1'b1;
            end else begin
                state_nxt.pc = state_cur.pc + PC_W'(1);
                case (instr.opcode)
                    OP_MOV: begin
                        if (a_in_range) state_nxt.regs[instr.a_reg] = b_val;
                    end
                    OP_ADD, OP_SUB, OP_MUL: begin
                        case (instr.opcode)
                            OP_ADD:  alu_res = a_val + b_val;
                            OP_SUB:  alu_res = a_val - b_val;
                            default: alu_res = DATA_W'(a_val * b_val);
                        endcase
                        if (a_in_range) state_nxt.regs[instr.a_reg] = alu_res;
                        state_nxt.zero     = alu_res == '0;
                        state_nxt.negative = alu_res[DATA_W-1];
                    end
                    OP_CMP: begin
                        state_nxt.zero = cmp_a == b_val;
                    end
                    OP_JMP: begin
                        state_nxt.pc = {1'b0, instr.jump_target};
                    end
                    OP_JZ: begin
                        if (state_cur.zero) state_nxt.pc = {1'b0, instr.jump_target};
                    end
                    OP_PRINT: begin
                        result.print_valid = 1'b1;
                        result.print_reg   = instr.a_reg;
                        result.print_value = a_val;
                    end
                    default: begin
                        state_nxt.halt = 1'b1;
                    end
                endcase
                if (state_nxt.pc >= PC_W'(PROGRAM_SIZE)) state_nxt.halt = 1'b1;
            end
        end
        result.next_pc      = state_nxt.pc;
        result.halted       = state_nxt.halt;
        result.zero_out     = state_nxt.zero;
        result.negative_out = state_nxt.negative;
    end

endmodule

### rtl/four_register_instruction_executor_top.sv
// Top level: input register, execute logic, result register and core state.
// A beat moves from the input register into the result register when that register
// is empty or m_ready is high. Throughput: one instruction per cycle unless m_ready
// stalls; the execute path (register read, one 32x32 multiply, flag detect) sits
// between the registers. Core state updates when a beat enters the result register.
// Synchronous active-low reset clears registers, flags, pc, halt and both valids.
module four_register_instruction_executor_top
    import frie_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [3:0]               s_opcode,
    input  logic                     s_a_is_reg,
    input  logic [1:0]               s_a_reg,
    input  logic [3:0]               s_a_imm,
    input  logic                     s_b_is_reg,
    input  logic [1:0]               s_b_reg,
    input  logic signed [DATA_W-1:0] s_b_imm,
    input  logic [6:0]               s_jump_target,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [PC_W-1:0]          m_next_pc,
    output logic                     m_halted,
    output logic                     m_print_valid,
    output logic [1:0]               m_print_reg,
    output logic signed [DATA_W-1:0] m_print_value,
    output logic                     m_zero_out,
    output logic                     m_negative_out
);

    logic        in_valid_reg;
    instr_t      instr_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    core_state_t state_reg;
    core_state_t state_next;
    result_t     result_next;
    logic        exec_fire;

    assign exec_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || exec_fire;

    frie_exec u_exec (
        .instr     (instr_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (exec_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (exec_fire) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            instr_reg <= '{opcode: s_opcode, a_is_reg: s_a_is_reg, a_reg: s_a_reg,
                           a_imm: s_a_imm, b_is_reg: s_b_is_reg, b_reg: s_b_reg,
                           b_imm: s_b_imm, jump_target: s_jump_target};
        end
        if (exec_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_next_pc      = result_reg.next_pc;
    assign m_halted       = result_reg.halted;
    assign m_print_valid  = result_reg.print_valid;
    assign m_print_reg    = result_reg.print_reg;
    assign m_print_value  = result_reg.print_value;
    assign m_zero_out     = result_reg.zero_out;
    assign m_negative_out = result_reg.negative_out;

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.halt |=> state_reg.halt)
        else $error("halt mark cleared without reset");

    a_halted_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.halt && exec_fire |=> $stable(state_reg))
        else $error("core state changed while halted");

    a_print_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_print_valid |-> m_print_value == '0 && m_print_reg == '0)
        else $error("print fields set on a non-print beat");

    a_running_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_halted |-> m_next_pc < PC_W'(PROGRAM_SIZE))
        else $error("running core reports pc past program end");

    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |=> m_next_pc == state_reg.pc && m_halted == state_reg.halt
                      && m_zero_out == state_reg.zero)
        else $error("result beat disagrees with updated core state");
`endif

endmodule

### tb/tb_four_register_instruction_executor_top.sv
// Self-checking testbench for the four-register instruction executor: scoreboard, stimulus, checks.
module tb_four_register_instruction_executor_top;

    import frie_pkg::*;

    class exec_scoreboard;
        logic [DATA_W-1:0] regs [REGISTER_COUNT];
        logic              zero_flag;
        logic              neg_flag;
        logic [PC_W-1:0]   pc;
        logic              halted;
        result_t           expected_results [$];
        int                error_count;

        function new();
            foreach (regs[i]) regs[i] = '0;
            zero_flag   = 1'b0;
            neg_flag    = 1'b0;
            pc          = '0;
            halted      = 1'b0;
            error_count = 0;
        endfunction

        function logic [DATA_W-1:0] read_reg(logic [1:0] idx);
            if (int'(idx) >= REGISTER_COUNT) return '0;
            return regs[idx];
        endfunction

        function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] v);
            if (int'(idx) < REGISTER_COUNT) regs[idx] = v;
        endfunction

        function void set_flags(logic [DATA_W-1:0] v);
            zero_flag = (v == '0);
            neg_flag  = v[DATA_W-1];
        endfunction

        function void execute_instr(instr_t ins);
            logic [DATA_W-1:0] b;
            logic [DATA_W-1:0] r;
            result_t           res;
            res = '0;
            if (!halted) begin
                if (int'(pc) >= PROGRAM_SIZE) begin
                    halted = 1'b1;
                end else begin
                    b  = ins.b_is_reg ? read_reg(ins.b_reg) : ins.b_imm;
                    pc = pc + PC_W'(1);
                    case (ins.opcode)
                        OP_MOV: write_reg(ins.a_reg, b);
                        OP_ADD: begin
                            r = read_reg(ins.a_reg) + b;
                            write_reg(ins.a_reg, r);
                            set_flags(r);
                        end
                        OP_SUB: begin
                            r = read_reg(ins.a_reg) - b;
                            write_reg(ins.a_reg, r);
                            set_flags(r);
                        end
                        OP_MUL: begin
                            r = read_reg(ins.a_reg) * b;
                            write_reg(ins.a_reg, r);
                            set_flags(r);
                        end
                        OP_CMP: begin
                            r = ins.a_is_reg ? read_reg(ins.a_reg) : DATA_W'(ins.a_imm);
                            zero_flag = (r == b);
                        end
                        OP_JMP: pc = PC_W'(ins.jump_target);
                        OP_JZ: begin
                            if (zero_flag) pc = PC_W'(ins.jump_target);
                        end
                        OP_PRINT: begin
                            res.print_valid = 1'b1;
                            res.print_reg   = ins.a_reg;
                            res.print_value = read_reg(ins.a_reg);
                        end
                        default: halted = 1'b1;
                    endcase
                    if (int'(pc) >= PROGRAM_SIZE) halted = 1'b1;
                end
            end
            res.next_pc      = pc;
            res.halted       = halted;
            res.zero_out     = zero_flag;
            res.negative_out = neg_flag;
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                error_count++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                $error("result beat with no instruction outstanding");
                error_count++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("next_pc", DATA_W'(want.next_pc), DATA_W'(got.next_pc));
            compare_field("halted", DATA_W'(want.halted), DATA_W'(got.halted));
            compare_field("print_valid", DATA_W'(want.print_valid),
                          DATA_W'(got.print_valid));
            compare_field("print_reg", DATA_W'(want.print_reg), DATA_W'(got.print_reg));
            compare_field("print_value", want.print_value, got.print_value);
            compare_field("zero_out", DATA_W'(want.zero_out), DATA_W'(got.zero_out));
            compare_field("negative_out", DATA_W'(want.negative_out),
                          DATA_W'(got.negative_out));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic [3:0]               s_opcode      = '0;
    logic                     s_a_is_reg    = 1'b0;
    logic [1:0]               s_a_reg       = '0;
    logic [3:0]               s_a_imm       = '0;
    logic                     s_b_is_reg    = 1'b0;
    logic [1:0]               s_b_reg       = '0;
    logic signed [DATA_W-1:0] s_b_imm       = '0;
    logic [6:0]               s_jump_target = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic [PC_W-1:0]          m_next_pc;
    logic                     m_halted;
    logic                     m_print_valid;
    logic [1:0]               m_print_reg;
    logic signed [DATA_W-1:0] m_print_value;
    logic                     m_zero_out;
    logic                     m_negative_out;

    exec_scoreboard sb;
    bit             send_burst   = 1'b0;
    bit             recv_burst   = 1'b0;
    int             items_sent   = 0;
    int             results_seen = 0;
    int             hold_left    = 0;

    four_register_instruction_executor_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_a_is_reg     (s_a_is_reg),
        .s_a_reg        (s_a_reg),
        .s_a_imm        (s_a_imm),
        .s_b_is_reg     (s_b_is_reg),
        .s_b_reg        (s_b_reg),
        .s_b_imm        (s_b_imm),
        .s_jump_target  (s_jump_target),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_next_pc      (m_next_pc),
        .m_halted       (m_halted),
        .m_print_valid  (m_print_valid),
        .m_print_reg    (m_print_reg),
        .m_print_value  (m_print_value),
        .m_zero_out     (m_zero_out),
        .m_negative_out (m_negative_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic instr_t mk(logic [3:0] op, logic a_is_reg, logic [1:0] a_reg,
                                  logic [3:0] a_imm, logic b_is_reg, logic [1:0] b_reg,
                                  logic [DATA_W-1:0] b_imm, logic [6:0] target);
        instr_t ins;
        ins.opcode      = op;
        ins.a_is_reg    = a_is_reg;
        ins.a_reg       = a_reg;
        ins.a_imm       = a_imm;
        ins.b_is_reg    = b_is_reg;
        ins.b_reg       = b_reg;
        ins.b_imm       = b_imm;
        ins.jump_target = target;
        return ins;
    endfunction

    function automatic instr_t pick_instr(logic [PC_W-1:0] pc_now);
        instr_t ins;
        int     sel;
        sel = $urandom_range(0, 99);
        if (int'(pc_now) >= PROGRAM_SIZE - 2) ins.opcode = OP_JMP;
        else if (sel < 12)              ins.opcode = OP_MOV;
        else if (sel < 26)              ins.opcode = OP_ADD;
        else if (sel < 40)              ins.opcode = OP_SUB;
        else if (sel < 52)              ins.opcode = OP_MUL;
        else if (sel < 70)              ins.opcode = OP_CMP;
        else if (sel < 76)              ins.opcode = OP_JMP;
        else if (sel < 88)              ins.opcode = OP_JZ;
        else                            ins.opcode = OP_PRINT;
        ins.a_is_reg    = 1'($urandom_range(0, 1));
        ins.a_reg       = 2'($urandom_range(0, 3));
        ins.a_imm       = 4'($urandom_range(0, 9));
        ins.b_is_reg    = 1'($urandom_range(0, 1));
        ins.b_reg       = 2'($urandom_range(0, 3));
        ins.jump_target = 7'($urandom_range(0, 127));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ins.b_imm = $urandom_range(0, 9);
            4:          ins.b_imm = 32'h8000_0000;
            5:          ins.b_imm = 32'h7FFF_FFFF;
            6:          ins.b_imm = -$urandom_range(1, 9);
            default:    ins.b_imm = $urandom;
        endcase
        if (ins.opcode == OP_CMP && $urandom_range(0, 2) == 0) begin
            ins.a_is_reg = 1'b0;
            ins.b_is_reg = 1'b0;
            ins.b_imm    = DATA_W'(ins.a_imm);
        end
        return ins;
    endfunction

    task automatic send_instr(input instr_t ins);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= ins.opcode;
        s_a_is_reg    <= ins.a_is_reg;
        s_a_reg       <= ins.a_reg;
        s_a_imm       <= ins.a_imm;
        s_b_is_reg    <= ins.b_is_reg;
        s_b_reg       <= ins.b_reg;
        s_b_imm       <= ins.b_imm;
        s_jump_target <= ins.jump_target;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.execute_instr(ins);
        items_sent++;
        if (items_sent % 100 == 0) send_burst = ($urandom_range(0, 3) == 0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                sb.check_result(result_t'{next_pc: m_next_pc, halted: m_halted,
                                          print_valid: m_print_valid,
                                          print_reg: m_print_reg,
                                          print_value: m_print_value,
                                          zero_out: m_zero_out,
                                          negative_out: m_negative_out});
                results_seen++;
                if (results_seen % 100 == 0) recv_burst = ($urandom_range(0, 3) == 0);
                hold_left = recv_burst ? 0 : $urandom_range(0, 15);
            end else if (m_valid && hold_left != 0) begin
                hold_left--;
            end
            m_ready <= (hold_left == 0);
        end
    end

    initial begin
        #4_000_000;
        $display("four_register_instruction_executor_top regression: fail");
        $finish;
    end

    initial begin
        instr_t ins;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_instr(mk(OP_MOV,   0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0));
        send_instr(mk(OP_ADD,   0, 0, 0, 0, 0, 32'd1, 0));
        send_instr(mk(OP_MOV,   0, 1, 0, 0, 0, 32'h8000_0000, 0));
        send_instr(mk(OP_SUB,   0, 1, 0, 0, 0, 32'd1, 0));
        send_instr(mk(OP_MOV,   0, 2, 0, 0, 0, 32'hFFFF_FFFF, 0));
        send_instr(mk(OP_ADD,   0, 2, 0, 0, 0, 32'd1, 0));
        send_instr(mk(OP_MOV,   0, 3, 0, 1, 0, 32'd0, 0));
        send_instr(mk(OP_MUL,   0, 3, 0, 0, 0, 32'd2, 0));
        send_instr(mk(OP_MUL,   0, 0, 0, 1, 1, 32'd0, 0));
        send_instr(mk(OP_CMP,   0, 0, 9, 0, 0, 32'd9, 0));
        send_instr(mk(OP_JZ,    0, 0, 0, 0, 0, 32'd0, 7'd20));
        send_instr(mk(OP_CMP,   0, 0, 0, 0, 0, 32'd5, 0));
        send_instr(mk(OP_JZ,    0, 0, 0, 0, 0, 32'd0, 7'd127));
        send_instr(mk(OP_CMP,   1, 1, 0, 1, 1, 32'd0, 0));
        send_instr(mk(OP_JZ,    0, 0, 0, 0, 0, 32'd0, 7'd127));
        send_instr(mk(OP_JMP,   0, 0, 0, 0, 0, 32'd0, 7'd0));
        send_instr(mk(OP_JMP,   0, 0, 0, 0, 0, 32'd0, 7'd127));
        send_instr(mk(OP_JMP,   0, 0, 0, 0, 0, 32'd0, 7'd64));
        send_instr(mk(OP_PRINT, 0, 0, 0, 0, 0, 32'd0, 0));
        send_instr(mk(OP_PRINT, 0, 1, 0, 0, 0, 32'd0, 0));
        send_instr(mk(OP_PRINT, 0, 2, 0, 0, 0, 32'd0, 0));
        send_instr(mk(OP_PRINT, 0, 3, 0, 0, 0, 32'd0, 0));
        send_instr(mk(OP_SUB,   0, 0, 0, 0, 0, 32'h8000_0000, 0));
        send_instr(mk(OP_MUL,   0, 1, 0, 0, 0, 32'hFFFF_FFFF, 0));
        send_instr(mk(OP_CMP,   1, 2, 0, 0, 0, 32'd0, 0));
        wait_drained();

        for (int n = 0; n < 1900; n++) begin
            if (n == 950) wait_drained();
            send_instr(pick_instr(sb.pc));
        end

        // stop the program: either an unknown opcode or a run past the last address
        if ($urandom_range(0, 1) == 0) begin
            ins        = pick_instr(sb.pc);
            ins.opcode = 4'($urandom_range(8, 15));
            send_instr(ins);
        end else begin
            if (int'(sb.pc) != PROGRAM_SIZE - 1) begin
                ins             = pick_instr(0);
                ins.opcode      = OP_JMP;
                ins.jump_target = 7'd127;
                send_instr(ins);
            end
            ins        = pick_instr(0);
            ins.opcode = $urandom_range(0, 1) ? OP_PRINT : OP_MOV;
            send_instr(ins);
        end

        // halted: every further beat must be ignored
        repeat (30) begin
            ins        = pick_instr(0);
            ins.opcode = 4'($urandom_range(0, 15));
            send_instr(ins);
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("four_register_instruction_executor_top regression: pass");
        end else begin
            $display("four_register_instruction_executor_top regression: fail");
        end
        $finish;
    end

endmodule

### four_register_instruction_executor_top.f
rtl/frie_pkg.sv
rtl/frie_exec.sv
rtl/four_register_instruction_executor_top.sv
tb/tb_four_register_instruction_executor_top.sv
